FILE: rtl/core/ray_triangle_intersect_defines.svh
// Assertion macros for the ray / triangle block.
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`ifndef SYNTHESIS
`define RTI_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rti: implication check failed");
`define RTI_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rti: next-cycle check failed");
`else
`define RTI_ASSERT_IMP(name, clk, rst, ante, cons)
`define RTI_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/rti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;
   localparam int CW   = 20;
   localparam int FW   = 12;
   localparam int DW   = 24;
   localparam int EW   = CW + 1;
   localparam int XW   = 2 * EW;
   localparam int HW   = XW / 2;
   localparam int LW   = XW + 1;
   localparam int PW   = 64;
   localparam int TW   = 40;
   localparam int VW   = 3 * CW;
   localparam int RW   = DW - FW;
   localparam int MW   = DW + 1 + CW;
   localparam int IDW  = 6 * CW + 2 * DW;
   localparam int ODW  = ((DW + 3 * CW + 7) / 8) * 8;
   localparam int PADW = ODW - (DW + 3 * CW);
   localparam int AW   = 5;
   localparam int BW   = 64;

   localparam int NXT1 [3] = '{1, 2, 0};
   localparam int NXT2 [3] = '{2, 0, 1};

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [EW-1:0] edge_type;
   typedef logic signed [XW-1:0] cross_type;
   typedef logic signed [LW-1:0] lo_type;
   typedef logic signed [PW-1:0] wide_type;
   typedef logic signed [MW-1:0] mul_type;
   typedef logic [DW-1:0]        dist_type;

   localparam coord_type CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(CW-1){1'b0}}};

   typedef enum logic [1:0] {
      REG_VERTEX_ZERO,
      REG_VERTEX_ONE,
      REG_VERTEX_TWO,
      REG_THRESHOLD
   } reg_idx_type;

   typedef struct {
      coord_type org [3];
      coord_type dir [3];
      dist_type  near_lim;
      dist_type  far_lim;
   } ray_type;

   typedef struct {
      ray_type   ray;
      edge_type  e1 [3];
      edge_type  e2 [3];
      edge_type  s  [3];
      cross_type h  [3];
      cross_type q  [3];
   } geom_type;

   typedef struct {
      logic          miss;
      logic [PW-1:0] ad;
      logic [PW-1:0] rem;
      logic [RW-1:0] tlow;
      ray_type       ray;
   } seed_type;

   typedef struct {
      logic     miss;
      dist_type traw;
      ray_type  ray;
   } quot_type;

   typedef struct packed {
      coord_type pz;
      coord_type py;
      coord_type px;
      dist_type  hit_dist;
      logic      is_hit;
   } result_type;

   function automatic edge_type vcoord(input logic [VW-1:0] v, input int k);
      coord_type c;
      c = coord_type'(v[k*CW +: CW]);
      return edge_type'(c);
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/ray_triangle_intersect.sv
// channel   | dir | handshake              | contents
// req_      | in  | req_tvalid/req_tready  | ray: origin, direction, near/far window
// rsp_      | out | rsp_tvalid/rsp_tready  | hit flag (tuser), distance and hit point
// csr_      | in  | APB write/read         | three vertices, parallel threshold
//
// One ray per cycle unless held by rsp_tready; each ray passes through the
// cross/dot pipeline and the 24-stage divider (one quotient bit per stage).
// Synchronous reset clears all stage valids and the configuration registers.
// The whole pipeline holds while a result waits on rsp_tready; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "ray_triangle_intersect_defines.svh"
module ray_triangle_intersect (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // origin_x/y/z, direction_x/y/z, near_limit, far_limit
   input  logic [rti_pkg::IDW-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // hit_distance, point_x, point_y, point_z, zero pad
   output logic [rti_pkg::ODW-1:0] rsp_tdata,
   // is_hit
   output logic                    rsp_tuser,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [rti_pkg::AW-1:0]  csr_paddr,
   input  logic [rti_pkg::BW-1:0]  csr_pwdata,
   output logic [rti_pkg::BW-1:0]  csr_prdata,
   output logic                    csr_pready
);
   logic                     adv;
   logic                     wr_en;
   rti_pkg::reg_idx_type     reg_idx;
   logic [rti_pkg::VW-1:0]   vtx0_ff, vtx1_ff, vtx2_ff;
   logic [rti_pkg::TW-1:0]   thresh_ff;
   rti_pkg::ray_type         req_ray;
   logic                     geom_valid, seed_valid, quot_valid, point_valid;
   rti_pkg::geom_type        geom;
   rti_pkg::seed_type        seed;
   rti_pkg::quot_type        quot;
   rti_pkg::result_type      point_res;
   logic                     rsp_valid_ff;
   rti_pkg::result_type      rsp_res_ff;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = rti_pkg::reg_idx_type'(csr_paddr[rti_pkg::AW-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vtx0_ff   <= '0;
         vtx1_ff   <= '0;
         vtx2_ff   <= '0;
         thresh_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            rti_pkg::REG_VERTEX_ZERO: vtx0_ff   <= csr_pwdata[rti_pkg::VW-1:0];
            rti_pkg::REG_VERTEX_ONE:  vtx1_ff   <= csr_pwdata[rti_pkg::VW-1:0];
            rti_pkg::REG_VERTEX_TWO:  vtx2_ff   <= csr_pwdata[rti_pkg::VW-1:0];
            rti_pkg::REG_THRESHOLD:   thresh_ff <= csr_pwdata[rti_pkg::TW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rti_pkg::REG_VERTEX_ZERO: csr_prdata = rti_pkg::BW'(vtx0_ff);
         rti_pkg::REG_VERTEX_ONE:  csr_prdata = rti_pkg::BW'(vtx1_ff);
         rti_pkg::REG_VERTEX_TWO:  csr_prdata = rti_pkg::BW'(vtx2_ff);
         rti_pkg::REG_THRESHOLD:   csr_prdata = rti_pkg::BW'(thresh_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         req_ray.org[k] = req_tdata[k*rti_pkg::CW +: rti_pkg::CW];
         req_ray.dir[k] = req_tdata[(3+k)*rti_pkg::CW +: rti_pkg::CW];
      end
      req_ray.near_lim = req_tdata[6*rti_pkg::CW +: rti_pkg::DW];
      req_ray.far_lim  = req_tdata[6*rti_pkg::CW+rti_pkg::DW +: rti_pkg::DW];
   end

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   rti_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_ray    (req_ray),
      .vtx0      (vtx0_ff),
      .vtx1      (vtx1_ff),
      .vtx2      (vtx2_ff),
      .out_valid (geom_valid),
      .out_geom  (geom)
   );

   rti_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (geom_valid),
      .in_geom   (geom),
      .thresh    (thresh_ff),
      .out_valid (seed_valid),
      .out_seed  (seed)
   );

   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (seed_valid),
      .in_seed   (seed),
      .out_valid (quot_valid),
      .out_quot  (quot)
   );

   rti_point u_point (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (quot_valid),
      .in_quot   (quot),
      .out_valid (point_valid),
      .out_res   (point_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= point_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_res_ff <= point_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.is_hit;
   assign rsp_tdata  = {{rti_pkg::PADW{1'b0}}, rsp_res_ff.pz, rsp_res_ff.py,
                        rsp_res_ff.px, rsp_res_ff.hit_dist};

   `RTI_ASSERT_IMP(a_miss_zero, clock, reset,
      rsp_valid_ff && !rsp_res_ff.is_hit,
      rsp_res_ff.hit_dist == '0 && rsp_res_ff.px == '0
         && rsp_res_ff.py == '0 && rsp_res_ff.pz == '0)
   `RTI_ASSERT_IMP(a_hit_dist, clock, reset,
      rsp_valid_ff && rsp_res_ff.is_hit, rsp_res_ff.hit_dist != '0)
   `RTI_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid_ff && !quot_valid)
endmodule
`default_nettype wire

FILE: rtl/core/rti_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rti_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  rti_pkg::ray_type       in_ray,
   input  logic [rti_pkg::VW-1:0] vtx0,
   input  logic [rti_pkg::VW-1:0] vtx1,
   input  logic [rti_pkg::VW-1:0] vtx2,
   output logic                   out_valid,
   output rti_pkg::geom_type      out_geom
);
   logic [2:0]         valid_ff;
   rti_pkg::ray_type   ray0_ff, ray1_ff;
   rti_pkg::edge_type  e1_0_in [3], e2_0_in [3], s_0_in [3];
   rti_pkg::edge_type  e1_0_ff [3], e2_0_ff [3], s_0_ff [3];
   rti_pkg::edge_type  e1_1_ff [3], e2_1_ff [3], s_1_ff [3];
   rti_pkg::cross_type hp_in [6], qp_in [6], hp_ff [6], qp_ff [6];
   rti_pkg::geom_type  geom_in, geom_ff;

   // edges and origin offset
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e1_0_in[k] = rti_pkg::vcoord(vtx1, k) - rti_pkg::vcoord(vtx0, k);
         e2_0_in[k] = rti_pkg::vcoord(vtx2, k) - rti_pkg::vcoord(vtx0, k);
         s_0_in[k]  = rti_pkg::edge_type'(in_ray.org[k]) - rti_pkg::vcoord(vtx0, k);
      end
   end

   // cross product terms: h = dir x e2, q = s x e1
   always_comb begin
      int a, b;
      for (int k = 0; k < 3; k++) begin
         a = rti_pkg::NXT1[k];
         b = rti_pkg::NXT2[k];
         hp_in[2*k]   = rti_pkg::cross_type'(rti_pkg::edge_type'(ray0_ff.dir[a]) * e2_0_ff[b]);
         hp_in[2*k+1] = rti_pkg::cross_type'(rti_pkg::edge_type'(ray0_ff.dir[b]) * e2_0_ff[a]);
         qp_in[2*k]   = rti_pkg::cross_type'(s_0_ff[a] * e1_0_ff[b]);
         qp_in[2*k+1] = rti_pkg::cross_type'(s_0_ff[b] * e1_0_ff[a]);
      end
   end

   always_comb begin
      geom_in.ray = ray1_ff;
      for (int k = 0; k < 3; k++) begin
         geom_in.e1[k] = e1_1_ff[k];
         geom_in.e2[k] = e2_1_ff[k];
         geom_in.s[k]  = s_1_ff[k];
         geom_in.h[k]  = hp_ff[2*k] - hp_ff[2*k+1];
         geom_in.q[k]  = qp_ff[2*k] - qp_ff[2*k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ray0_ff <= in_ray;
         ray1_ff <= ray0_ff;
         e1_0_ff <= e1_0_in;
         e2_0_ff <= e2_0_in;
         s_0_ff  <= s_0_in;
         e1_1_ff <= e1_0_ff;
         e2_1_ff <= e2_0_ff;
         s_1_ff  <= s_0_ff;
         hp_ff   <= hp_in;
         qp_ff   <= qp_in;
         geom_ff <= geom_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_geom  = geom_ff;
endmodule
`default_nettype wire

FILE: rtl/core/rti_dot.sv
`timescale 1ns / 1ps
`default_nettype none
module rti_dot (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  rti_pkg::geom_type      in_geom,
   input  logic [rti_pkg::TW-1:0] thresh,
   output logic                   out_valid,
   output rti_pkg::seed_type      out_seed
);
   logic [4:0]              valid_ff;
   rti_pkg::ray_type        ray_ff [4];
   rti_pkg::edge_type       xs [12];
   rti_pkg::cross_type      ys [12];
   rti_pkg::cross_type      hi_in [12], hi_ff [12];
   rti_pkg::lo_type         lo_in [12], lo_ff [12];
   rti_pkg::wide_type       prod_in [12], prod_ff [12];
   rti_pkg::wide_type       dot_in [4], dot_ff [4];
   rti_pkg::wide_type       un_in, vn_in, tn_in, un_ff, vn_ff, tn_ff;
   logic [rti_pkg::PW-1:0]  ad_in, ad_ff, rem0;
   logic [rti_pkg::PW:0]    sum_uv;
   rti_pkg::seed_type       seed_in, seed_ff;
   logic                    neg;

   // operand pairs: e1.h, s.h, dir.q, e2.q
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         xs[k]   = in_geom.e1[k];
         ys[k]   = in_geom.h[k];
         xs[3+k] = in_geom.s[k];
         ys[3+k] = in_geom.h[k];
         xs[6+k] = rti_pkg::edge_type'(in_geom.ray.dir[k]);
         ys[6+k] = in_geom.q[k];
         xs[9+k] = in_geom.e2[k];
         ys[9+k] = in_geom.q[k];
      end
      for (int i = 0; i < 12; i++) begin
         hi_in[i] = rti_pkg::cross_type'(xs[i] * $signed(ys[i][rti_pkg::XW-1:rti_pkg::HW]));
         lo_in[i] = rti_pkg::lo_type'(xs[i] * $signed({1'b0, ys[i][rti_pkg::HW-1:0]}));
      end
   end

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         prod_in[i] = (rti_pkg::wide_type'(hi_ff[i]) <<< rti_pkg::HW)
                      + rti_pkg::wide_type'(lo_ff[i]);
      end
      for (int d = 0; d < 4; d++) begin
         dot_in[d] = prod_ff[3*d] + prod_ff[3*d+1] + prod_ff[3*d+2];
      end
   end

   // fold the determinant sign into the numerators
   always_comb begin
      neg   = dot_ff[0][rti_pkg::PW-1];
      ad_in = neg ? $unsigned(-dot_ff[0]) : $unsigned(dot_ff[0]);
      un_in = neg ? -dot_ff[1] : dot_ff[1];
      vn_in = neg ? -dot_ff[2] : dot_ff[2];
      tn_in = neg ? -dot_ff[3] : dot_ff[3];
   end

   always_comb begin
      rem0   = $unsigned(tn_ff) >> rti_pkg::RW;
      sum_uv = {1'b0, $unsigned(un_ff)} + {1'b0, $unsigned(vn_ff)};
      seed_in.miss = (ad_ff == '0)
                   | (ad_ff <= rti_pkg::PW'(thresh))
                   | un_ff[rti_pkg::PW-1]
                   | ($unsigned(un_ff) > ad_ff)
                   | vn_ff[rti_pkg::PW-1]
                   | (sum_uv > {1'b0, ad_ff})
                   | tn_ff[rti_pkg::PW-1]
                   | (rem0 >= ad_ff);
      seed_in.ad   = ad_ff;
      seed_in.rem  = rem0;
      seed_in.tlow = tn_ff[rti_pkg::RW-1:0];
      seed_in.ray  = ray_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ray_ff[0] <= in_geom.ray;
         ray_ff[1] <= ray_ff[0];
         ray_ff[2] <= ray_ff[1];
         ray_ff[3] <= ray_ff[2];
         hi_ff     <= hi_in;
         lo_ff     <= lo_in;
         prod_ff   <= prod_in;
         dot_ff    <= dot_in;
         ad_ff     <= ad_in;
         un_ff     <= un_in;
         vn_ff     <= vn_in;
         tn_ff     <= tn_in;
         seed_ff   <= seed_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_seed  = seed_ff;
endmodule
`default_nettype wire

FILE: rtl/core/rti_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rti_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  rti_pkg::seed_type in_seed,
   output logic              out_valid,
   output rti_pkg::quot_type out_quot
);
   typedef struct {
      logic                   miss;
      logic [rti_pkg::PW-1:0] ad;
      logic [rti_pkg::PW-1:0] rem;
      logic [rti_pkg::DW-1:0] nlow;
      rti_pkg::dist_type      q;
      rti_pkg::ray_type       ray;
   } stage_type;

   logic [rti_pkg::DW-1:0] valid_ff, src_valid;
   stage_type              src [rti_pkg::DW];
   stage_type              stage_in [rti_pkg::DW];
   stage_type              stage_ff [rti_pkg::DW];

   always_comb begin
      src[0].miss = in_seed.miss;
      src[0].ad   = in_seed.ad;
      src[0].rem  = in_seed.rem;
      src[0].nlow = {in_seed.tlow, {rti_pkg::FW{1'b0}}};
      src[0].q    = '0;
      src[0].ray  = in_seed.ray;
      src_valid[0] = in_valid;
      for (int j = 1; j < rti_pkg::DW; j++) begin
         src[j]       = stage_ff[j-1];
         src_valid[j] = valid_ff[j-1];
      end
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar j = 0; j < rti_pkg::DW; j++) begin : g_stage
      localparam int P = rti_pkg::DW - 1 - j;
      logic [rti_pkg::PW-1:0] cand;
      logic                   take;
      always_comb begin
         cand = {src[j].rem[rti_pkg::PW-2:0], src[j].nlow[P]};
         take = (cand >= src[j].ad);
         stage_in[j]      = src[j];
         stage_in[j].rem  = take ? cand - src[j].ad : cand;
         stage_in[j].q[P] = take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid     = valid_ff[rti_pkg::DW-1];
   assign out_quot.miss = stage_ff[rti_pkg::DW-1].miss;
   assign out_quot.traw = stage_ff[rti_pkg::DW-1].q;
   assign out_quot.ray  = stage_ff[rti_pkg::DW-1].ray;
endmodule
`default_nettype wire

FILE: rtl/core/rti_point.sv
`timescale 1ns / 1ps
`default_nettype none
module rti_point (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rti_pkg::quot_type   in_quot,
   output logic                out_valid,
   output rti_pkg::result_type out_res
);
   logic                valid_ff;
   logic                miss_in, miss_ff;
   rti_pkg::dist_type   traw_ff;
   rti_pkg::coord_type  org_ff [3];
   rti_pkg::mul_type    prod_in [3], prod_ff [3];
   rti_pkg::coord_type  pt [3];

   always_comb begin
      miss_in = in_quot.miss
              | (in_quot.traw == '0)
              | (in_quot.traw < in_quot.ray.near_lim)
              | (in_quot.traw > in_quot.ray.far_lim);
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = rti_pkg::mul_type'($signed({1'b0, in_quot.traw}) * in_quot.ray.dir[k]);
      end
   end

   // t*dir truncated toward zero, then saturating add
   always_comb begin
      rti_pkg::mul_type mag, step, sum;
      for (int k = 0; k < 3; k++) begin
         mag  = prod_ff[k][rti_pkg::MW-1] ? -prod_ff[k] : prod_ff[k];
         step = rti_pkg::mul_type'($unsigned(mag) >> rti_pkg::FW);
         if (prod_ff[k][rti_pkg::MW-1]) begin
            step = -step;
         end
         sum = rti_pkg::mul_type'(org_ff[k]) + step;
         if (sum > rti_pkg::mul_type'(rti_pkg::CMAX)) begin
            pt[k] = rti_pkg::CMAX;
         end else if (sum < rti_pkg::mul_type'(rti_pkg::CMIN)) begin
            pt[k] = rti_pkg::CMIN;
         end else begin
            pt[k] = sum[rti_pkg::CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         miss_ff <= miss_in;
         traw_ff <= in_quot.traw;
         org_ff  <= in_quot.ray.org;
         prod_ff <= prod_in;
      end
   end

   assign out_valid        = valid_ff;
   assign out_res.is_hit   = !miss_ff;
   assign out_res.hit_dist = miss_ff ? '0 : traw_ff;
   assign out_res.px       = miss_ff ? '0 : pt[0];
   assign out_res.py       = miss_ff ? '0 : pt[1];
   assign out_res.pz       = miss_ff ? '0 : pt[2];
endmodule
`default_nettype wire
